// ===== rtl/prld_pkg.sv =====
// ----------------------------------------------------------------------------
// prld_pkg: shared types and constants of the readout lane deframer
// Frame geometry, markers, result kinds and the per-lane result bundle.
// ----------------------------------------------------------------------------
package prld_pkg;

	localparam int LANES           = 8;
	localparam int PIXELS_PER_LANE = 128;
	localparam int BITS_PER_PIXEL  = 203;
	localparam int TRAILER_WORDS   = 8;

	localparam int SLOTS       = 4;   // bit slots (bytes) per readout word
	localparam int TOTAL_BITS  = PIXELS_PER_LANE * BITS_PER_PIXEL;
	localparam int DATA_WORDS  = (TOTAL_BITS + SLOTS - 1) / SLOTS;
	localparam int WC_W        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int SEL_BITS    = SLOTS * LANES;
	localparam int MAX_SAMPLES = 8;

	localparam logic [7:0]  HDR_MARK  = 8'hAC;
	localparam logic [31:0] TRL_MARK  = 32'h0FFF_EFFF;
	localparam logic [7:0]  POS_LAST  = 8'(BITS_PER_PIXEL - 1);
	localparam logic [6:0]  PIX_LAST  = 7'(PIXELS_PER_LANE - 1);
	localparam logic [3:0]  TRL_LAST  = 4'(TRAILER_WORDS);

	typedef enum logic [2:0] {
		KIND_HDR_OK  = 3'd0,
		KIND_HDR_BAD = 3'd1,
		KIND_SAMPLE  = 3'd2,
		KIND_END     = 3'd3,
		KIND_END_TMO = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		AL_WAIT,
		AL_RUN,
		AL_DONE
	} align_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  column;
		logic [4:0]  row;
		logic [2:0]  time_bin;
		logic [7:0]  adc_value;
		logic [9:0]  tdc_value;
		logic        discriminator;
		logic [7:0]  pixel_header;
	} res_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] slot;   // bit slot of the word that completed this result
		res_t       res;
	} lane_res_t;

endpackage

// ===== rtl/prld_lane.sv =====
// ----------------------------------------------------------------------------
// prld_lane: one lane decoder
// Takes four bits per word, aligns, cuts frames and builds header and samples.
// ----------------------------------------------------------------------------
module prld_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  en,
	input  logic [2:0]            lane_id,
	input  logic [3:0]            bits,     // bit of slot b at [b]
	output prld_pkg::lane_res_t   res
);
	import prld_pkg::*;

	align_t      al_q, al_d;
	logic [7:0]  pos_q, pos_d;
	logic [6:0]  pix_q, pix_d;
	logic [7:0]  sh_q, sh_d;
	logic [15:0] part_q, part_d;
	logic [1:0]  ix_q, ix_d;
	logic [3:0]  si_q, si_d;
	lane_res_t   r;

	always_comb begin
		logic       go;
		logic [7:0] bv;
		logic [23:0] sw;
		al_d   = al_q;
		pos_d  = pos_q;
		pix_d  = pix_q;
		sh_d   = sh_q;
		part_d = part_q;
		ix_d   = ix_q;
		si_d   = si_q;
		r      = '0;
		bv     = '0;
		sw     = '0;
		for (int b = 0; b < SLOTS; b++) begin
			go = 1'b1;
			if (al_d == AL_DONE) begin
				go = 1'b0;
			end else if (al_d == AL_WAIT) begin
				al_d = AL_RUN;
				if (!bits[b]) go = 1'b0;   // leading zero is dropped
			end
			if (go) begin
				bv   = {sh_d[6:0], bits[b]};
				sh_d = bv;
				if (pos_d[2:0] == 3'd7) begin
					if (pos_d[7:3] == 5'd0) begin
						r.vld              = en;
						r.slot             = 2'(b);
						r.res.kind         = (bv == HDR_MARK) ? KIND_HDR_OK : KIND_HDR_BAD;
						r.res.column       = {lane_id, 2'b00} + 5'(pix_d >> 5);
						r.res.row          = pix_d[4:0];
						r.res.pixel_header = bv;
					end else begin
						unique case (ix_d)
							2'd0: begin
								part_d = {8'h00, bv};
								ix_d   = 2'd1;
							end
							2'd1: begin
								part_d = {part_d[7:0], bv};
								ix_d   = 2'd2;
							end
							default: begin
								sw = {part_d, bv};
								if (si_d < 4'(MAX_SAMPLES)) begin
									r.vld               = en;
									r.slot              = 2'(b);
									r.res.kind          = KIND_SAMPLE;
									r.res.column        = {lane_id, 2'b00} + 5'(pix_d >> 5);
									r.res.row           = pix_d[4:0];
									r.res.time_bin      = si_d[2:0];
									r.res.adc_value     = sw[20:13];
									r.res.tdc_value     = sw[9:0];
									r.res.discriminator = sw[12];
								end
								part_d = '0;
								ix_d   = 2'd0;
								si_d   = si_d + 4'd1;
							end
						endcase
					end
					sh_d = '0;
				end
				if (pos_d == POS_LAST) begin
					// frame done: drop the tail bits, next pixel
					pos_d  = '0;
					sh_d   = '0;
					part_d = '0;
					ix_d   = '0;
					si_d   = '0;
					if (pix_d == PIX_LAST) begin
						pix_d = '0;
						al_d  = AL_DONE;
					end else begin
						pix_d = pix_d + 7'd1;
					end
				end else begin
					pos_d = pos_d + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_q   <= AL_WAIT;
			pos_q  <= '0;
			pix_q  <= '0;
			sh_q   <= '0;
			part_q <= '0;
			ix_q   <= '0;
			si_q   <= '0;
		end else if (clr) begin
			al_q   <= AL_WAIT;
			pos_q  <= '0;
			pix_q  <= '0;
			sh_q   <= '0;
			part_q <= '0;
			ix_q   <= '0;
			si_q   <= '0;
		end else if (en) begin
			al_q   <= al_d;
			pos_q  <= pos_d;
			pix_q  <= pix_d;
			sh_q   <= sh_d;
			part_q <= part_d;
			ix_q   <= ix_d;
			si_q   <= si_d;
		end
	end

	assign res = r;

endmodule

// ===== rtl/prld_merge.sv =====
// ----------------------------------------------------------------------------
// prld_merge: result merger
// Holds the lane results of one word and drains them in slot, then lane order.
// ----------------------------------------------------------------------------
module prld_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  prld_pkg::lane_res_t [prld_pkg::LANES-1:0] ent,
	output logic                                ready,
	output logic                                out_valid,
	input  logic                                out_ready,
	output prld_pkg::res_t                      out_res,
	output logic                                out_last
);
	import prld_pkg::*;

	lane_res_t [LANES-1:0] ent_q;
	logic [LANES-1:0]      vld_q;
	logic [LANES-1:0]      new_vld;
	logic [LANES-1:0]      sel_oh;
	logic [LANE_W-1:0]     sel;
	logic                  found;
	logic                  any_pend;
	logic                  one_left;
	logic                  mv;
	logic                  out_vld_q;
	res_t                  out_q;
	logic                  last_q;

	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int b = 0; b < SLOTS; b++) begin
			for (int l = 0; l < LANES; l++) begin
				if (!found && vld_q[l] && (ent_q[l].slot == 2'(b))) begin
					found = 1'b1;
					sel   = LANE_W'(l);
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sel_oh[l]  = (sel == LANE_W'(l)) && found;
			new_vld[l] = ent[l].vld;
		end
	end

	assign any_pend = |vld_q;
	assign one_left = ((vld_q & ~sel_oh) == '0);
	assign mv       = any_pend && (!out_vld_q || out_ready);
	assign ready    = !any_pend || (mv && one_left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q <= new_vld;
			end else if (mv) begin
				vld_q <= vld_q & ~sel_oh;
			end
			if (mv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) ent_q <= ent;
		if (mv) begin
			out_q  <= ent_q[sel].res;
			last_q <= one_left;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;
	assign out_last  = last_q;

	// a new word only lands when the previous one has fully drained
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!any_pend || (mv && one_left)))
		else $error("merge: word loaded over pending results");

	// a drain pick is a single pending lane
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		any_pend |-> ($onehot(sel_oh) && ((sel_oh & ~vld_q) == '0)))
		else $error("merge: bad lane pick");

	// the last result of a word leaves the buffer empty unless a word is loaded
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mv && one_left && !load) |=> !any_pend)
		else $error("merge: results left after last");

endmodule

// ===== rtl/pixel_readout_lane_deframer.sv =====
// ----------------------------------------------------------------------------
// pixel_readout_lane_deframer: readout word to pixel result deframer
// Eight lane decoders split each word's bits; a merger serializes the results.
// ----------------------------------------------------------------------------
// Path: lane decode of a taken word lands in the result buffer at the accepting
//   edge; the output register that drives m_tvalid then loads from that buffer.
// Throughput: one word per cycle while each word yields at most one result
//   and m_tready does not hold the output register; a word that completes more
//   than one result holds s_tready low until the single output register drains the buffer.
// Reset (arst_n low, async): fast_command_mode = 1, header phase, all lanes
//   awaiting their first bit, result buffer and output empty.
// ----------------------------------------------------------------------------
module pixel_readout_lane_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: fast_command_mode
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_word
	input  logic        s_tuser,   // [0] op (1 = start of event)
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // column, row, time_bin, adc_value, tdc_value,
	                               // discriminator, pixel_header (low bit up)
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);
	import prld_pkg::*;

	logic                  mode_q;
	phase_t                phase_q, phase_d;
	logic                  hdr_cnt_q;
	logic [WC_W-1:0]       wc_q;
	logic [3:0]            trl_q;
	logic                  tmo_q;

	logic                  acc;
	logic                  start;
	logic                  lane_en;
	logic                  trl_en;
	logic                  is_mark;
	logic                  end_fire;
	logic                  tmo_now;

	lane_res_t [LANES-1:0] lane_res;
	lane_res_t [LANES-1:0] ent;
	res_t                  out_res;
	logic                  out_last;

	assign acc     = s_tvalid && s_tready;
	assign start   = acc && s_tuser;
	assign is_mark = (s_tdata == TRL_MARK);

	// config register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// ---- event phase: next state ----
	always_comb begin
		phase_d = phase_q;
		if (start) begin
			phase_d = PH_HEADER;
		end else if (acc) begin
			unique case (phase_q)
				PH_HEADER:  if (hdr_cnt_q) phase_d = PH_DATA;
				PH_DATA:    if (wc_q == WC_W'(DATA_WORDS - 1)) phase_d = PH_TRAILER;
				PH_TRAILER: if (end_fire) phase_d = PH_DONE;
				PH_DONE:    phase_d = PH_DONE;
			endcase
		end
	end

	// ---- event phase: outputs ----
	always_comb begin
		lane_en  = 1'b0;
		trl_en   = 1'b0;
		unique case (phase_q)
			PH_DATA:    lane_en = acc && !s_tuser;
			PH_TRAILER: trl_en  = acc && !s_tuser;
			default: ;
		endcase
		// timeout lives in bit 0 of the word right after the marker
		tmo_now  = (trl_q == 4'd1) ? s_tdata[0] : tmo_q;
		end_fire = trl_en && !is_mark && (trl_q != 4'd0) && ((trl_q + 4'd1) == TRL_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 1'b0;
			wc_q      <= '0;
			trl_q     <= '0;
			tmo_q     <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (start) begin
				hdr_cnt_q <= 1'b0;
				wc_q      <= '0;
				trl_q     <= '0;
				tmo_q     <= 1'b0;
			end else begin
				// two header words are swallowed
				if (acc && phase_q == PH_HEADER) hdr_cnt_q <= !hdr_cnt_q;
				if (lane_en) wc_q <= wc_q + WC_W'(1);
				if (trl_en) begin
					if (is_mark) begin
						trl_q <= 4'd1;
					end else if (trl_q != 4'd0) begin
						if (trl_q == 4'd1) tmo_q <= s_tdata[0];
						trl_q <= trl_q + 4'd1;
					end
				end
			end
		end
	end

	// ---- lanes: fast mode feeds bit l of every byte to lane l;
	//      single mode feeds lane 0 a one for every nonzero byte ----
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [3:0] bits;
		logic       en;
		if (g == 0) begin : g_first
			assign bits = mode_q ?
				{s_tdata[24], s_tdata[16], s_tdata[8], s_tdata[0]} :
				{|s_tdata[31:24], |s_tdata[23:16], |s_tdata[15:8], |s_tdata[7:0]};
			assign en   = lane_en;
		end else begin : g_rest
			assign bits = {s_tdata[24+g], s_tdata[16+g], s_tdata[8+g], s_tdata[g]};
			assign en   = lane_en && mode_q;
		end

		prld_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (start),
			.en      (en),
			.lane_id (3'(g)),
			.bits    (bits),
			.res     (lane_res[g])
		);
	end

	// event end rides in lane 0's entry; lanes are idle in the trailer
	always_comb begin
		ent = lane_res;
		if (end_fire) begin
			ent[0]          = '0;
			ent[0].vld      = 1'b1;
			ent[0].res.kind = tmo_now ? KIND_END_TMO : KIND_END;
		end
	end

	prld_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (acc),
		.ent       (ent),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_last  (out_last)
	);

	assign m_tuser = out_res.kind;
	assign m_tlast = out_last;
	assign m_tdata = {out_res.pixel_header, out_res.discriminator, out_res.tdc_value,
	                  out_res.adc_value, out_res.time_bin, out_res.row, out_res.column};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_readout_lane_deframer
// Streams readout words built from per-lane frame streams through the block,
// predicts every pixel header, sample and event end word in a local deframer
// model and compares them in order. Idle mixes and mode settings vary by phase.
// ----------------------------------------------------------------------------
module tb;
	import prld_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 7;
	localparam int MAX_RESULTS    = 8;     // most result words one input word can cause
	localparam int SETTLE_CYCLES  = 20;    // block may still be busy on a silent word
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
	localparam int PHASE_WORDS    = 50;    // random words per phase
	localparam int MAX_PRINTED    = 40;

	// idle mixes
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_SEND   = 1;
	localparam int IDLE_RECV   = 2;
	localparam int IDLE_BOTH   = 3;

	typedef struct packed {
		logic        op;
		logic [31:0] data;
	} readout_word_t;

	typedef struct packed {
		res_t res;
		logic last;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	pixel_readout_lane_deframer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	readout_word_t words_to_send[$];
	pixel_result_t pixel_results_due[$];
	pixel_result_t word_results[$];
	int unsigned   mismatch_count = 0;
	int unsigned   words_queued = 0;
	int            idle_mode = IDLE_NONE;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	int unsigned   hold_left = 0;
	int unsigned   quiet_cycles = 0;

	// ------------------------------------------------------------------
	// Deframer model state
	// ------------------------------------------------------------------
	logic          fast_mode;
	phase_t        ev_phase;
	logic          hdr_word_seen;
	int unsigned   lane0_bits;
	align_t        lane_align[LANES];
	int unsigned   lane_pos[LANES];
	int unsigned   lane_pix[LANES];
	logic [7:0]    lane_shift[LANES];
	logic [15:0]   lane_part[LANES];
	int unsigned   trl_count;
	logic          tmo_seen;

	function automatic void clear_event();
		ev_phase      = PH_HEADER;
		hdr_word_seen = 1'b0;
		lane0_bits    = 0;
		trl_count     = 0;
		tmo_seen      = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			lane_align[l] = AL_WAIT;
			lane_pos[l]   = 0;
			lane_pix[l]   = 0;
			lane_shift[l] = '0;
			lane_part[l]  = '0;
		end
	endfunction

	function automatic void push_result(kind_t k, logic [4:0] col, logic [4:0] row,
			logic [2:0] tbin, logic [7:0] adc, logic [9:0] tdc, logic disc,
			logic [7:0] hdr);
		pixel_result_t r;
		if (word_results.size() >= MAX_RESULTS)
			return;
		r.res.kind          = k;
		r.res.column        = col;
		r.res.row           = row;
		r.res.time_bin      = tbin;
		r.res.adc_value     = adc;
		r.res.tdc_value     = tdc;
		r.res.discriminator = disc;
		r.res.pixel_header  = hdr;
		r.last              = 1'b0;
		word_results.push_back(r);
	endfunction

	// one bit into one lane: MSB-first byte assembly, header byte, 24-bit samples
	function automatic void feed_lane(int l, logic b);
		int unsigned pos, pix, k, ix, s;
		logic [4:0]  col, row;
		logic [7:0]  byte_v;
		logic [23:0] smp;
		if (lane_align[l] == AL_DONE)
			return;
		if (lane_align[l] == AL_WAIT) begin
			// a leading zero is dropped, a leading one starts frame 0
			lane_align[l] = AL_RUN;
			if (!b)
				return;
		end
		pos = lane_pos[l];
		pix = lane_pix[l];
		col = 5'(l * 4 + pix / 32);
		row = 5'(pix % 32);
		byte_v = {lane_shift[l][6:0], b};
		lane_shift[l] = byte_v;
		if (pos % 8 == 7) begin
			k = pos / 8;
			if (k == 0) begin
				if (byte_v == HDR_MARK)
					push_result(KIND_HDR_OK, col, row, '0, '0, '0, 1'b0, byte_v);
				else
					push_result(KIND_HDR_BAD, col, row, '0, '0, '0, 1'b0, byte_v);
			end else begin
				ix = (k - 1) % 3;
				s  = (k - 1) / 3;
				if (ix == 0) begin
					lane_part[l] = {8'h00, byte_v};
				end else if (ix == 1) begin
					lane_part[l] = {lane_part[l][7:0], byte_v};
				end else begin
					smp = {lane_part[l], byte_v};
					// samples past the eighth in a frame are dropped
					if (s < MAX_SAMPLES)
						push_result(KIND_SAMPLE, col, row, 3'(s), smp[20:13], smp[9:0],
							smp[12], 8'h00);
					lane_part[l] = '0;
				end
			end
			lane_shift[l] = '0;
		end
		pos++;
		if (pos >= BITS_PER_PIXEL) begin
			// frame tail bits past the last whole byte are lost here
			pos = 0;
			lane_shift[l] = '0;
			lane_part[l]  = '0;
			pix++;
			if (pix >= PIXELS_PER_LANE) begin
				pix = 0;
				lane_align[l] = AL_DONE;
			end
		end
		lane_pos[l] = pos;
		lane_pix[l] = pix;
	endfunction

	// expected result words of one accepted readout word, appended in order
	function automatic void deframe_word(logic op, logic [31:0] w);
		pixel_result_t r;
		word_results.delete();
		if (op) begin
			clear_event();
			return;
		end
		case (ev_phase)
			PH_HEADER: begin
				if (hdr_word_seen) begin
					hdr_word_seen = 1'b0;
					ev_phase = PH_DATA;
				end else begin
					hdr_word_seen = 1'b1;
				end
			end
			PH_DATA: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (fast_mode) begin
						for (int l = 0; l < LANES; l++)
							feed_lane(l, w[8 * s + l]);
					end else begin
						feed_lane(0, |w[8 * s +: 8]);
					end
				end
				lane0_bits += SLOTS;
				if (lane0_bits >= TOTAL_BITS)
					ev_phase = PH_TRAILER;
			end
			PH_TRAILER: begin
				// marker always restarts the count; words before any marker ignored
				if (w == TRL_MARK) begin
					trl_count = 1;
				end else if (trl_count != 0) begin
					if (trl_count == 1)
						tmo_seen = w[0];
					trl_count = (trl_count + 1) % 16;
					if (trl_count == TRAILER_WORDS) begin
						if (tmo_seen)
							push_result(KIND_END_TMO, '0, '0, '0, '0, '0, 1'b0, 8'h00);
						else
							push_result(KIND_END, '0, '0, '0, '0, '0, 1'b0, 8'h00);
						ev_phase = PH_DONE;
					end
				end
			end
			default: ;
		endcase
		if (word_results.size() != 0) begin
			r = word_results.pop_back();
			r.last = 1'b1;
			word_results.push_back(r);
		end
		foreach (word_results[i])
			pixel_results_due.push_back(word_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus streams: per-lane frames with mostly good header bytes
	// ------------------------------------------------------------------
	logic        stim_fast = 1'b1;
	int unsigned gen_pos[LANES];
	logic        gen_lead[LANES];
	logic [7:0]  gen_hdr[LANES];

	function automatic void restart_streams();
		for (int l = 0; l < LANES; l++) begin
			gen_pos[l]  = 0;
			gen_lead[l] = ($urandom_range(3) == 0);
		end
	endfunction

	function automatic logic next_stream_bit(int l);
		logic b;
		if (gen_lead[l]) begin
			gen_lead[l] = 1'b0;
			return 1'b0;
		end
		if (gen_pos[l] == 0)
			gen_hdr[l] = ($urandom_range(7) == 0) ? 8'($urandom) : HDR_MARK;
		if (gen_pos[l] < 8)
			b = gen_hdr[l][7 - gen_pos[l]];
		else
			b = 1'($urandom);
		gen_pos[l] = (gen_pos[l] + 1) % BITS_PER_PIXEL;
		return b;
	endfunction

	function automatic logic [31:0] next_data_word();
		logic [31:0] w;
		logic        b;
		w = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (stim_fast) begin
				for (int l = 0; l < LANES; l++)
					w[8 * s + l] = next_stream_bit(l);
			end else begin
				b = next_stream_bit(0);
				if (b)
					w[8 * s +: 8] = 8'($urandom_range(255, 1));
			end
		end
		// streams still advance, so a noisy word keeps frame alignment
		if ($urandom_range(19) == 0)
			w = $urandom;
		return w;
	endfunction

	function automatic void add_word(logic op, logic [31:0] data);
		readout_word_t it;
		it.op   = op;
		it.data = data;
		words_to_send.push_back(it);
		words_queued++;
	endfunction

	function automatic void add_event(int unsigned n_data, logic with_start);
		if (with_start) begin
			add_word(1'b1, $urandom);
			add_word(1'b0, $urandom);
			add_word(1'b0, $urandom);
			restart_streams();
		end
		repeat (n_data)
			add_word(1'b0, next_data_word());
	endfunction

	// ------------------------------------------------------------------
	// Driver: one word per handshake, held while s_tready is low
	// ------------------------------------------------------------------
	function automatic logic sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 58;
			IDLE_BOTH: return $urandom_range(99) < 7;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 58;
			IDLE_BOTH: return $urandom_range(99) < 7;
			default:   return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		readout_word_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				deframe_word(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (words_to_send.size() != 0 && !sender_idles()) begin
					nxt = words_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.op;
					s_tdata  <= nxt.data;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !receiver_stalls();
		end
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d data 0x%0h",
					m_tuser, m_tdata));
			end else begin
				want = pixel_results_due.pop_front();
				check_field("kind",          m_tuser,        want.res.kind);
				check_field("column",        m_tdata[4:0],   want.res.column);
				check_field("row",           m_tdata[9:5],   want.res.row);
				check_field("time_bin",      m_tdata[12:10], want.res.time_bin);
				check_field("adc_value",     m_tdata[20:13], want.res.adc_value);
				check_field("tdc_value",     m_tdata[30:21], want.res.tdc_value);
				check_field("discriminator", m_tdata[31],    want.res.discriminator);
				check_field("pixel_header",  m_tdata[39:32], want.res.pixel_header);
				check_field("last",          m_tlast,        want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------
	task automatic drain();
		@(negedge clk);
		while (words_to_send.size() != 0 || s_tvalid || pixel_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fast_mode(logic v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		fast_mode = v;
		stim_fast = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_idle(int m);
		@(posedge clk);
		idle_mode <= m;
	endtask

	// short random events; the first one carries on the previous event
	task automatic random_events();
		int unsigned start;
		logic        first;
		start = words_queued;
		first = 1'b1;
		@(negedge clk);
		while (words_queued - start < PHASE_WORDS) begin
			add_event($urandom_range(40), !first && ($urandom_range(5) != 0));
			first = 1'b0;
		end
	endtask

	initial begin
		fast_mode = 1'b1;
		clear_event();
		restart_streams();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: ignored data on start, all lanes aligned with good headers,
		// full-scale and zero samples, then dropped lead bit and a bad header
		@(negedge clk);
		add_word(1'b1, 32'hFFFF_FFFF);
		add_word(1'b0, 32'hFFFF_FFFF);
		add_word(1'b0, 32'h0000_0000);
		add_word(1'b0, 32'h00FF_00FF);
		add_word(1'b0, 32'h0000_FFFF);
		repeat (6) add_word(1'b0, 32'hFFFF_FFFF);
		repeat (6) add_word(1'b0, 32'h0000_0000);
		add_word(1'b1, 32'h0000_0000);
		add_word(1'b0, 32'h0000_0000);
		add_word(1'b0, 32'hFFFF_FFFF);
		add_word(1'b0, 32'hFF00_FF00);
		add_word(1'b0, 32'hFF00_FF00);
		add_word(1'b0, 32'h0000_00FF);
		add_word(1'b0, 32'hAAAA_AAAA);
		add_word(1'b0, 32'h5555_5555);
		drain();

		// single lane mode, sender gaps
		set_fast_mode(1'b0);
		set_idle(IDLE_SEND);
		random_events();
		drain();

		// eight lanes, receiver stalls
		set_fast_mode(1'b1);
		set_idle(IDLE_RECV);
		random_events();
		drain();

		set_fast_mode(1'b0);
		set_idle(IDLE_BOTH);
		random_events();
		drain();

		// eight lanes at full rate while the receiver holds off for a long stretch
		set_fast_mode(1'b1);
		@(posedge clk);
		idle_mode <= IDLE_NONE;
		hold_req  <= 1'b1;
		random_events();
		drain();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
